// ===== rtl/core/rga_pkg.sv =====
// ----------------------------------------------------------------------------
// rga_pkg
// Shared types and fixed field widths of the run group averager.
// ----------------------------------------------------------------------------
package rga_pkg;

   // fixed widths of the result fields and the control register
   localparam int AVG_W       = 16;
   localparam int COUNT_W     = 16;
   localparam int CSR_W       = 16;
   localparam int RSP_TDATA_W = AVG_W + COUNT_W;

   // update command from the sequencer to the group tracker
   typedef struct packed {
      logic place;    // join the open group, or open one if none is open
      logic reopen;   // drop the open group and start a new one with the sample
      logic clear;    // close everything, no group left open
   } grp_cmd_type;

endpackage

// ===== rtl/core/rga_divider.sv =====
// ----------------------------------------------------------------------------
// rga_divider
// Radix-2 restoring divider, one quotient bit per cycle. Divides a signed
// group sum by an unsigned member count, truncating toward zero.
// ----------------------------------------------------------------------------
module rga_divider #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COUNT_BITS   = 16,
   localparam int SUM_W       = SAMPLE_WIDTH + COUNT_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start_i,
   input  logic signed [SUM_W-1:0]        dividend_i,
   input  logic        [COUNT_BITS-1:0]   divisor_i,
   output logic                           done_o,
   output logic signed [SAMPLE_WIDTH-1:0] quotient_o
);

   localparam int STEP_W = $clog2(SAMPLE_WIDTH + 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    neg_ff, neg_in;
   logic [COUNT_BITS-1:0]   dsr_ff, dsr_in;
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [SAMPLE_WIDTH-1:0] dvd_ff, dvd_in;

   logic [SUM_W-1:0]        mag;
   logic [COUNT_BITS:0]     trial;
   logic                    qbit;

   // magnitude of the dividend; the average fits the sample range, so the
   // bits above the low SAMPLE_WIDTH ones are already below the divisor
   always_comb begin
      mag   = dividend_i[SUM_W-1] ? $unsigned(-dividend_i) : $unsigned(dividend_i);
      trial = {rem_ff, dvd_ff[SAMPLE_WIDTH-1]};
      qbit  = (trial >= {1'b0, dsr_ff});
   end

   // one shift-subtract step per cycle, quotient bits shift in from below
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      if (start_i) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SAMPLE_WIDTH);
         neg_in  = dividend_i[SUM_W-1];
         dsr_in  = divisor_i;
         rem_in  = mag[SUM_W-1:SAMPLE_WIDTH];
         dvd_in  = mag[SAMPLE_WIDTH-1:0];
      end else if (busy_ff) begin
         rem_in  = qbit ? COUNT_BITS'(trial - {1'b0, dsr_ff}) : trial[COUNT_BITS-1:0];
         dvd_in  = {dvd_ff[SAMPLE_WIDTH-2:0], qbit};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   // restore the sign, truncation toward zero
   assign done_o     = done_ff;
   assign quotient_o = neg_ff ? $signed(-dvd_ff) : $signed(dvd_ff);

   // checks
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start_i |-> !busy_ff)
      else $error("divider started while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a finished run");
   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> $past(start_i))
      else $error("divider went busy without start");

endmodule

// ===== rtl/core/rga_tracker.sv =====
// ----------------------------------------------------------------------------
// rga_tracker
// Holds the open group (first sample, running sum, member count) and decides
// whether an incoming sample belongs to it.
// ----------------------------------------------------------------------------
module rga_tracker #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int MAX_GROUP    = 65535,
   localparam int CNT_W       = $clog2(MAX_GROUP + 1),
   localparam int SUM_W       = SAMPLE_WIDTH + CNT_W
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rga_pkg::grp_cmd_type           cmd_i,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
   input  logic [rga_pkg::CSR_W-1:0]      max_diff_i,
   output logic                           open_o,
   output logic                           fits_o,
   output logic signed [SUM_W-1:0]        sum_o,
   output logic        [CNT_W-1:0]        count_o
);
   import rga_pkg::*;

   localparam int CMP_W = (SAMPLE_WIDTH + 1 > CSR_W) ? SAMPLE_WIDTH + 1 : CSR_W;

   logic signed [SAMPLE_WIDTH-1:0] first_ff, first_in;
   logic signed [SUM_W-1:0]        sum_ff, sum_in;
   logic        [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                           open_ff, open_in;

   logic signed [SAMPLE_WIDTH:0]   diff;
   logic        [SAMPLE_WIDTH:0]   abs_diff;

   // distance to the group's first sample and the join test
   always_comb begin
      diff     = (SAMPLE_WIDTH + 1)'(sample_i) - (SAMPLE_WIDTH + 1)'(first_ff);
      abs_diff = diff[SAMPLE_WIDTH] ? $unsigned(-diff) : $unsigned(diff);
      fits_o   = open_ff && (CMP_W'(abs_diff) <= CMP_W'(max_diff_i))
                 && (cnt_ff < CNT_W'(MAX_GROUP));
   end

   // group update
   always_comb begin
      first_in = first_ff;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      open_in  = open_ff;
      priority if (cmd_i.clear) begin
         first_in = '0;
         sum_in   = '0;
         cnt_in   = '0;
         open_in  = 1'b0;
      end else if (cmd_i.reopen || (cmd_i.place && !open_ff)) begin
         first_in = sample_i;
         sum_in   = SUM_W'(sample_i);
         cnt_in   = CNT_W'(1);
         open_in  = 1'b1;
      end else if (cmd_i.place) begin
         sum_in   = sum_ff + SUM_W'(sample_i);
         cnt_in   = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         sum_ff   <= '0;
         cnt_ff   <= '0;
         open_ff  <= 1'b0;
      end else begin
         first_ff <= first_in;
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
         open_ff  <= open_in;
      end
   end

   assign open_o  = open_ff;
   assign sum_o   = sum_ff;
   assign count_o = cnt_ff;

endmodule

// ===== rtl/core/run_group_averager.sv =====
// ----------------------------------------------------------------------------
// run_group_averager
// Groups consecutive samples that stay near the group's first sample and
// reports each closed group's truncated average and member count.
// ----------------------------------------------------------------------------
// A word that closes no group is taken while the sequencer stays idle, and the
// next word follows. A word that closes a group starts the shared bit-serial
// divider; its result word is loaded in ST_OUT once the divider is done.
// A last word with nothing to close passes ST_FLUSH, ST_DIV and ST_OUT, one that
// also closes a group runs the divider twice; a stalled result word holds ST_OUT.
// Synchronous reset clears the sequencer, closes any group, empties the
// result register and sets max_diff to 0.
module run_group_averager #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int MAX_GROUP    = 65535,
   localparam int REQ_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_wr_en,
   input  logic [rga_pkg::CSR_W-1:0]       csr_wr_data,   // max_diff
   // sample words
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [REQ_TDATA_W-1:0]          req_tdata,     // sample
   input  logic                            req_tlast,     // last
   // result words
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rga_pkg::RSP_TDATA_W-1:0] rsp_tdata,     // average, count
   output logic                            rsp_tlast      // end_of_stream
);
   import rga_pkg::*;

   localparam int CNT_W = $clog2(MAX_GROUP + 1);
   localparam int SUM_W = SAMPLE_WIDTH + CNT_W;

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DIV   = 2'd1;
   localparam logic [1:0] ST_OUT   = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic                   flush_ff, flush_in;
   logic                   eos_ff, eos_in;
   logic [CNT_W-1:0]       res_cnt_ff, res_cnt_in;
   logic [CSR_W-1:0]       max_diff_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                           accept;
   logic                           closing;
   logic                           out_free;
   logic                           load_rsp;
   logic                           div_start;
   logic                           div_done;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic signed [SAMPLE_WIDTH-1:0] quot;
   logic signed [SUM_W-1:0]        grp_sum;
   logic        [CNT_W-1:0]        grp_cnt;
   logic                           grp_open;
   logic                           grp_fits;
   grp_cmd_type                    grp_cmd;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_diff_ff <= '0;
      end else if (csr_wr_en) begin
         max_diff_ff <= csr_wr_data;
      end
   end

   // input handshake and group decision
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign sample     = $signed(req_tdata[SAMPLE_WIDTH-1:0]);
   assign closing    = grp_open && !grp_fits;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign load_rsp   = (state_ff == ST_OUT) && out_free;
   assign div_start  = (accept && closing) || (state_ff == ST_FLUSH);

   always_comb begin
      grp_cmd.place  = accept && !closing;
      grp_cmd.reopen = accept && closing;
      grp_cmd.clear  = (state_ff == ST_FLUSH);
   end

   rga_tracker #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .MAX_GROUP    (MAX_GROUP)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .cmd_i      (grp_cmd),
      .sample_i   (sample),
      .max_diff_i (max_diff_ff),
      .open_o     (grp_open),
      .fits_o     (grp_fits),
      .sum_o      (grp_sum),
      .count_o    (grp_cnt)
   );

   rga_divider #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COUNT_BITS   (CNT_W)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .start_i    (div_start),
      .dividend_i (grp_sum),
      .divisor_i  (grp_cnt),
      .done_o     (div_done),
      .quotient_o (quot)
   );

   // sequencer
   always_comb begin
      state_in   = state_ff;
      flush_in   = flush_ff;
      eos_in     = eos_ff;
      res_cnt_in = res_cnt_ff;
      if (div_start) begin
         res_cnt_in = grp_cnt;
         eos_in     = (state_ff == ST_FLUSH);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (closing) begin
                  state_in = ST_DIV;
                  flush_in = req_tlast;
               end else if (req_tlast) begin
                  state_in = ST_FLUSH;
                  flush_in = 1'b0;
               end
            end
         end
         ST_FLUSH: begin
            state_in = ST_DIV;
            flush_in = 1'b0;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = flush_ff ? ST_FLUSH : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {COUNT_W'(res_cnt_ff), AVG_W'(quot)};
         rsp_last_in  = eos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eos_ff      <= eos_in;
      res_cnt_ff  <= res_cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
